// ===== src/b3s_pkg.sv =====
// ---------------------------------------------------------------------------
// b3s_pkg: shared types for the 3x3 binomial smoother
// Payload structs of the input and result channels, configuration register
// indexes and the per-item position flags carried down the pipeline.
// ---------------------------------------------------------------------------
package b3s_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic [15:0] sample;
    logic        frame_start;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [19:0] smoothed;
    logic [15:0] out_row;
    logic [6:0]  out_col;
    logic        last;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Position flags of one sample, worked out when it is accepted.
  typedef struct packed {
    logic emit;      // row is at least 1, so the row above is complete
    logic top_clamp; // row above is row 0, its upper neighbor clamps
    logic col_ge1;
    logic col_ge2;
    logic last_col;
    logic last_row;
  } pos_flags_t;

  localparam int unsigned ResultsPerItem = 4;

endpackage

// ===== src/binomial_3x3_smoother_unit.sv =====
// ---------------------------------------------------------------------------
// binomial_3x3_smoother_unit: streaming 3x3 binomial smoother
// Raster-order 16-bit samples in, exact 1-2-1 x 1-2-1 weighted sums out,
// with edge clamping, two line stores and a six-register window.
// ---------------------------------------------------------------------------
// The block takes one sample per cycle when not stalled and gives the result
// for the position one row up and one column left. Items that cause one result
// or none sustain one item per cycle unless the output stalls. A row's last
// sample past row 0 causes two results, and in the final row of a frame every
// item past the first column causes two, the row-end item four; the result
// queue drains one result per cycle unless the output stalls and holds the
// next item back until it is nearly empty, so later items wait for the drain.
// The two line stores are memories with a registered read, read when a sample
// is accepted and written when it leaves the compute stage; a sample at the
// same column as the one ahead of it gets that sample's values through a
// bypass. The stores need no clearing after reset. Width and height are
// written over the configuration port; the user must write them only while
// the block is idle, as the block itself does not enforce this.
module binomial_3x3_smoother_unit
  import b3s_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = (CW + 1 > 8) ? CW + 1 : 8;

  // Configuration registers.
  logic [7:0]  width_q;
  logic [15:0] height_q;

  // Position counters of the next sample.
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;

  // Compute stage.
  logic          s1_valid_q, s1_valid_d;
  logic [15:0]   s1_sample_q;
  logic [CW-1:0] s1_col_q;
  logic [15:0]   s1_row_q;
  pos_flags_t    s1_flags_q, flags_d;
  logic [15:0]   older_rd_q, prev_rd_q;

  // Line stores and window.
  logic [15:0] older_mem [MAX_WIDTH];
  logic [15:0] prev_mem  [MAX_WIDTH];
  logic [15:0] win_q [6];

  // Result queue.
  out_t       res_q [ResultsPerItem];
  out_t       res_d [ResultsPerItem];
  logic [2:0] cnt_q, cnt_d;

  logic in_take, out_take, s1_go, bypass;

  // ---------------- configuration port ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd100;
      height_q <= 16'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[7:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- position of the accepted sample ----------------
  logic [EW-1:0] w_eff, col_pre, c_ext, c_inc;
  logic [15:0]   h_eff, row_pre, r_cur;
  logic [16:0]   row_pre_inc, r_inc;
  logic [CW-1:0] c_cur;

  always_comb begin
    if (width_q < 8'd2) begin
      w_eff = EW'(2);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_q);
    end
    h_eff = (height_q < 16'd2) ? 16'd2 : height_q;

    col_pre     = in_data_i.frame_start ? '0 : EW'(col_q);
    row_pre     = in_data_i.frame_start ? '0 : row_q;
    row_pre_inc = 17'(row_pre) + 17'd1;

    // A column at or past the width ends the row before this sample.
    if (col_pre >= w_eff) begin
      c_ext = '0;
      r_cur = (row_pre_inc >= 17'(h_eff)) ? 16'd0 : row_pre_inc[15:0];
    end else begin
      c_ext = col_pre;
      r_cur = row_pre;
    end
    if (r_cur >= h_eff) begin
      r_cur = 16'd0;
    end
    c_cur = c_ext[CW-1:0];
    c_inc = c_ext + EW'(1);
    r_inc = 17'(r_cur) + 17'd1;

    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= 17'(h_eff)) ? 16'd0 : r_inc[15:0];
    end else begin
      col_d = c_inc[CW-1:0];
      row_d = r_cur;
    end

    flags_d.emit      = (r_cur != 16'd0);
    flags_d.top_clamp = (r_cur == 16'd1);
    flags_d.col_ge1   = (c_ext != '0);
    flags_d.col_ge2   = (c_ext >= EW'(2));
    flags_d.last_col  = (c_inc == w_eff);
    flags_d.last_row  = (r_inc == 17'(h_eff));
  end

  // ---------------- handshake ----------------
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign s1_go       = s1_valid_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_take));
  assign in_stall_o  = s1_valid_q && !s1_go;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);

  // The compute stage writes its column back on the edge the next sample
  // reads; on a match the store read is replaced by the departing values.
  assign bypass = s1_go && (s1_col_q == c_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      cnt_q      <= 3'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      if (in_take) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sample_q <= in_data_i.sample;
      s1_col_q    <= c_cur;
      s1_row_q    <= r_cur;
      s1_flags_q  <= flags_d;
      older_rd_q  <= bypass ? prev_rd_q   : older_mem[c_cur];
      prev_rd_q   <= bypass ? s1_sample_q : prev_mem[c_cur];
    end
    if (s1_go) begin
      older_mem[s1_col_q] <= prev_rd_q;
      prev_mem[s1_col_q]  <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= 16'd0;
      end
    end else if (s1_go) begin
      win_q[1] <= win_q[0];
      win_q[0] <= older_rd_q;
      win_q[3] <= win_q[2];
      win_q[2] <= prev_rd_q;
      win_q[5] <= win_q[4];
      win_q[4] <= s1_sample_q;
    end
  end

  // ---------------- weighted sums ----------------
  logic [15:0]   tn, mn, bn, t0, t1, t2;
  logic [17:0]   v0, v1, v2, u0, u1, u2, va, ua;
  logic [19:0]   sum_a, sum_b, sum_c, sum_d;
  logic [15:0]   row_up;
  logic [CW-1:0] col_left;
  logic [CW+6:0] col_here_ext, col_left_ext;

  always_comb begin
    tn = older_rd_q;
    mn = prev_rd_q;
    bn = s1_sample_q;
    t0 = s1_flags_q.top_clamp ? mn       : tn;
    t1 = s1_flags_q.top_clamp ? win_q[2] : win_q[0];
    t2 = s1_flags_q.top_clamp ? win_q[3] : win_q[1];

    v0 = 18'(t0) + {1'b0, mn, 1'b0} + 18'(bn);
    v1 = 18'(t1) + {1'b0, win_q[2], 1'b0} + 18'(win_q[4]);
    v2 = 18'(t2) + {1'b0, win_q[3], 1'b0} + 18'(win_q[5]);
    va = s1_flags_q.col_ge2 ? v2 : v1;
    sum_a = 20'(va) + {1'b0, v1, 1'b0} + 20'(v0);
    sum_b = 20'(v1) + {1'b0, v0, 1'b0} + 20'(v0);

    // In the final row the lower neighbor clamps to the row itself.
    u0 = 18'(mn) + {1'b0, bn, 1'b0} + 18'(bn);
    u1 = 18'(win_q[2]) + {1'b0, win_q[4], 1'b0} + 18'(win_q[4]);
    u2 = 18'(win_q[3]) + {1'b0, win_q[5], 1'b0} + 18'(win_q[5]);
    ua = s1_flags_q.col_ge2 ? u2 : u1;
    sum_c = 20'(ua) + {1'b0, u1, 1'b0} + 20'(u0);
    sum_d = 20'(u1) + {1'b0, u0, 1'b0} + 20'(u0);

    row_up       = s1_row_q - 16'd1;
    col_left     = s1_col_q - CW'(1);
    col_here_ext = {7'd0, s1_col_q};
    col_left_ext = {7'd0, col_left};
  end

  // ---------------- result batch ----------------
  out_t       cand  [ResultsPerItem];
  logic       cand_en [ResultsPerItem];
  out_t       batch [ResultsPerItem];
  logic [2:0] batch_n;
  logic [2:0] batch_top;

  always_comb begin
    cand[0] = '{smoothed: sum_a, out_row: row_up, out_col: col_left_ext[6:0], last: 1'b0};
    cand[1] = '{smoothed: sum_b, out_row: row_up, out_col: col_here_ext[6:0], last: 1'b0};
    cand[2] = '{smoothed: sum_c, out_row: s1_row_q, out_col: col_left_ext[6:0], last: 1'b0};
    cand[3] = '{smoothed: sum_d, out_row: s1_row_q, out_col: col_here_ext[6:0], last: 1'b0};
    cand_en[0] = s1_flags_q.emit && s1_flags_q.col_ge1;
    cand_en[1] = s1_flags_q.emit && s1_flags_q.last_col;
    cand_en[2] = s1_flags_q.emit && s1_flags_q.last_row && s1_flags_q.col_ge1;
    cand_en[3] = s1_flags_q.emit && s1_flags_q.last_row && s1_flags_q.last_col;

    batch_n = 3'd0;
    for (int i = 0; i < ResultsPerItem; i++) begin
      batch[i] = '0;
    end
    for (int i = 0; i < ResultsPerItem; i++) begin
      if (cand_en[i]) begin
        batch[batch_n[1:0]] = cand[i];
        batch_n = batch_n + 3'd1;
      end
    end
    batch_top = batch_n - 3'd1;
    if (batch_n != 3'd0) begin
      batch[batch_top[1:0]].last = 1'b1;
    end
  end

  // ---------------- result queue ----------------
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < ResultsPerItem; i++) begin
      res_d[i] = res_q[i];
    end
    if (out_take) begin
      for (int i = 0; i < ResultsPerItem - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      cnt_d = cnt_q - 3'd1;
    end
    if (s1_go) begin
      for (int i = 0; i < ResultsPerItem; i++) begin
        res_d[i] = batch[i];
      end
      cnt_d = batch_n;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResultsPerItem; i++) begin
      res_q[i] <= res_d[i];
    end
  end

  assign out_data_o = res_q[0];

  // ---------------- assertions ----------------
  a_load_nearly_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) s1_go |-> (cnt_q <= 3'd1))
    else $error("result queue loaded while holding more than one result");

  a_last_at_tail: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cnt_q == 3'd1)) |-> out_data_o.last)
    else $error("final queued result lacks the last flag");

  a_no_early_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 3'd1) |-> !out_data_o.last)
    else $error("last flag set ahead of further results of the same item");

  a_stall_needs_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (s1_valid_q && out_valid_o))
    else $error("input stalled with nothing in flight");

endmodule
